// File: rtl/core/newton_divided_difference_coefs_unit_macros.svh
// assertion macros for the divided-difference coefficient unit
// no dependencies
`ifndef NEWTON_DIVIDED_DIFFERENCE_COEFS_UNIT_MACROS_SVH
`define NEWTON_DIVIDED_DIFFERENCE_COEFS_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define NDD_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define NDD_ASSERT(label, prop) \
    `NDD_ASSERT_IMPL(label, i_clk, i_rst_n, prop)
`else
`define NDD_ASSERT_IMPL(label, clk, rst_n, prop)
`define NDD_ASSERT(label, prop)
`endif
`endif

// File: rtl/core/ndd_pkg.sv
// shared types and constants for the divided-difference coefficient unit
// no dependencies
`default_nettype none
package ndd_pkg;
    localparam int NODE_W = 17;
    localparam int Q_W = 32;
    localparam int NREC = 6;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_FIRST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_THIRD = 2'd2;
    localparam logic [NODE_W-1:0] NODE_FIRST_RST = 17'd10323;
    localparam logic [NODE_W-1:0] NODE_SECOND_RST = 17'd42113;
    localparam logic [NODE_W-1:0] NODE_THIRD_RST = 17'd65536;
    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh80000000;

    typedef logic signed [Q_W-1:0] t_q;

    typedef struct packed {
        logic busy;
        logic done;
    } t_rec_status;

    // a * f scaled by 2^-16, rounding half away from zero, with clipping
    function automatic logic [Q_W:0] mulq(input logic signed [Q_W:0] a,
                                          input logic signed [Q_W-1:0] f);
        logic signed [2*Q_W:0] p;
        logic [2*Q_W:0] m;
        logic [2*Q_W:0] r;
        logic neg;
        logic sat;
        logic signed [Q_W-1:0] v;
        p = 65'(a) * 65'(f);
        neg = p[2*Q_W];
        m = neg ? 65'(-p) : 65'(p);
        r = (m + 65'd32768) >> 16;
        sat = 1'b0;
        if (!neg && r > 65'(Q_MAX)) begin
            sat = 1'b1;
            v = Q_MAX;
        end else if (neg && r > 65'd2147483648) begin
            sat = 1'b1;
            v = Q_MIN;
        end else begin
            v = neg ? Q_W'(-r) : Q_W'(r);
        end
        return {sat, v};
    endfunction
endpackage
`default_nettype wire

// File: rtl/core/ndd_recip.sv
// node registers and reciprocal table, one long division per entry
// depends on ndd_pkg
`default_nettype none
`include "newton_divided_difference_coefs_unit_macros.svh"
module ndd_recip (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_write,
    input  wire logic [ndd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ndd_pkg::NODE_W-1:0] i_cfg_data,
    output ndd_pkg::t_q o_recip [ndd_pkg::NREC],
    output logic o_clip,
    output ndd_pkg::t_rec_status o_status
);
    logic [ndd_pkg::NODE_W-1:0] r_node [3];
    ndd_pkg::t_q r_recip [ndd_pkg::NREC];
    logic [ndd_pkg::NREC-1:0] r_clip;
    logic r_busy;
    logic [2:0] r_ent;
    logic [5:0] r_step;
    logic [33:0] r_rem;
    logic [33:0] r_quo;
    logic [17:0] r_div;
    logic r_neg;
    logic signed [18:0] n_diff;
    logic [34:0] n_trial;
    logic [33:0] n_shift;
    logic [34:0] n_round;

    always_comb begin
        case (r_ent)
            3'd0: n_diff = 19'(r_node[0]);
            3'd1: n_diff = 19'(r_node[1]) - 19'(r_node[2]);
            3'd2: n_diff = 19'(r_node[0]) - 19'(r_node[1]);
            3'd3: n_diff = 19'sd0 - 19'(r_node[1]);
            3'd4: n_diff = 19'(r_node[0]) - 19'(r_node[2]);
            default: n_diff = 19'sd0 - 19'(r_node[2]);
        endcase
    end

    // restoring division of 2^32 + d/2 by |d|, one quotient bit a cycle
    assign n_shift = {r_rem[32:0], r_quo[33]};
    assign n_trial = {1'b0, n_shift} - {17'd0, r_div};
    assign n_round = {1'b0, r_quo[32:0], ~n_trial[34]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node[0] <= ndd_pkg::NODE_FIRST_RST;
            r_node[1] <= ndd_pkg::NODE_SECOND_RST;
            r_node[2] <= ndd_pkg::NODE_THIRD_RST;
            r_busy <= 1'b1;
            r_ent <= 3'd0;
            r_step <= 6'd0;
            r_clip <= '0;
        end else if (i_cfg_write && i_cfg_index <= ndd_pkg::REG_NODE_THIRD) begin
            r_node[i_cfg_index] <= i_cfg_data;
            r_busy <= 1'b1;
            r_ent <= 3'd0;
            r_step <= 6'd0;
        end else if (r_busy) begin
            if (r_step == 6'd0) begin
                r_div <= n_diff[18] ? 18'(-n_diff) : 18'(n_diff);
                r_neg <= n_diff[18];
                r_rem <= '0;
                r_quo <= 34'h100000000 + 34'((n_diff[18] ? 18'(-n_diff) : 18'(n_diff)) >> 1);
                r_step <= 6'd1;
            end else if (r_step <= 6'd34) begin
                r_rem <= n_trial[34] ? n_shift : n_trial[33:0];
                r_quo <= n_round[33:0];
                r_step <= r_step + 6'd1;
            end else begin
                if (r_div == 18'd0) begin
                    r_recip[r_ent] <= ndd_pkg::Q_MAX;
                    r_clip[r_ent] <= 1'b1;
                end else if (!r_neg && r_quo > 34'h7fffffff) begin
                    r_recip[r_ent] <= ndd_pkg::Q_MAX;
                    r_clip[r_ent] <= 1'b1;
                end else if (r_neg && r_quo > 34'h80000000) begin
                    r_recip[r_ent] <= ndd_pkg::Q_MIN;
                    r_clip[r_ent] <= 1'b1;
                end else begin
                    r_recip[r_ent] <= r_neg ? 32'(-r_quo) : 32'(r_quo);
                    r_clip[r_ent] <= 1'b0;
                end
                r_step <= 6'd0;
                if (r_ent == 3'(ndd_pkg::NREC - 1)) begin
                    r_busy <= 1'b0;
                end else begin
                    r_ent <= r_ent + 3'd1;
                end
            end
        end
    end

    assign o_recip = r_recip;
    assign o_clip = |r_clip;
    assign o_status.busy = r_busy;
    assign o_status.done = !r_busy;

    `NDD_ASSERT(a_ent_range, r_ent < 3'(ndd_pkg::NREC))
    `NDD_ASSERT(a_step_range, r_step <= 6'd35)
    `NDD_ASSERT(a_idle_step, !r_busy |-> r_step == 6'd0)
endmodule
`default_nettype wire

// File: rtl/core/ndd_pipe.sv
// four-stage pipeline over the divided-difference triangle, three multiply stages
// depends on ndd_pkg
`default_nettype none
`include "newton_divided_difference_coefs_unit_macros.svh"
module ndd_pipe (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire ndd_pkg::t_q i_s0,
    input  wire ndd_pkg::t_q i_s1,
    input  wire ndd_pkg::t_q i_s2,
    input  wire ndd_pkg::t_q i_acc,
    input  wire logic i_last,
    input  wire ndd_pkg::t_q i_recip [ndd_pkg::NREC],
    input  wire logic i_clip,
    output logic o_valid,
    output ndd_pkg::t_q o_c0,
    output ndd_pkg::t_q o_c1,
    output ndd_pkg::t_q o_c2,
    output ndd_pkg::t_q o_c3,
    output logic o_last,
    output logic o_sat
);
    logic [3:0] r_v;
    ndd_pkg::t_q r_c0 [4];
    ndd_pkg::t_q r_c1 [4];
    ndd_pkg::t_q r_c2 [4];
    ndd_pkg::t_q r_c3 [4];
    logic [3:0] r_l;
    logic [3:0] r_s;
    logic [32:0] n_a3, n_a1, n_a2, n_b3, n_b2, n_d3;

    assign n_a3 = ndd_pkg::mulq(33'(i_s0), i_recip[0]);
    assign n_a1 = ndd_pkg::mulq(33'(i_s1) - 33'(i_s2), i_recip[1]);
    assign n_a2 = ndd_pkg::mulq(33'(i_s0) - 33'(i_s1), i_recip[2]);
    assign n_b3 = ndd_pkg::mulq(33'(r_c3[0]) - 33'(r_c2[0]), i_recip[3]);
    assign n_b2 = ndd_pkg::mulq(33'(r_c2[0]) - 33'(r_c1[0]), i_recip[4]);
    assign n_d3 = ndd_pkg::mulq(33'(r_c3[1]) - 33'(r_c2[1]), i_recip[5]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_c0[0] <= i_acc;
        r_c1[0] <= n_a1[31:0];
        r_c2[0] <= n_a2[31:0];
        r_c3[0] <= n_a3[31:0];
        r_l[0] <= i_last;
        r_s[0] <= i_clip | n_a1[32] | n_a2[32] | n_a3[32];
        r_c0[1] <= r_c0[0];
        r_c1[1] <= r_c1[0];
        r_c2[1] <= n_b2[31:0];
        r_c3[1] <= n_b3[31:0];
        r_l[1] <= r_l[0];
        r_s[1] <= r_s[0] | n_b2[32] | n_b3[32];
        r_c0[2] <= r_c0[1];
        r_c1[2] <= r_c1[1];
        r_c2[2] <= r_c2[1];
        r_c3[2] <= n_d3[31:0];
        r_l[2] <= r_l[1];
        r_s[2] <= r_s[1] | n_d3[32];
        r_c0[3] <= r_c0[2];
        r_c1[3] <= r_c1[2];
        r_c2[3] <= r_c2[2];
        r_c3[3] <= r_c3[2];
        r_l[3] <= r_l[2];
        r_s[3] <= r_s[2];
    end

    assign o_valid = r_v[3];
    assign o_c0 = r_c0[3];
    assign o_c1 = r_c1[3];
    assign o_c2 = r_c2[3];
    assign o_c3 = r_c3[3];
    assign o_last = r_l[3];
    assign o_sat = r_s[3];

    `NDD_ASSERT(a_valid_shift, r_v[0] |=> r_v[1])
    `NDD_ASSERT(a_valid_out, r_v[2] |=> o_valid)
    `NDD_ASSERT(a_clip_keep, r_v[1] && r_s[1] |=> r_s[2])
endmodule
`default_nettype wire

// File: rtl/core/newton_divided_difference_coefs_unit.sv
// top level of the divided-difference coefficient unit
// depends on ndd_pkg, ndd_recip, ndd_pipe
//
// channel   dir  transfer                        payload
// start     in   i_start && !o_busy              stages, accepted value, last
// result    out  o_strobe, one cycle             coefficients, last, saturated
// config    in   i_cfg_valid && o_cfg_ready      index, node value
//
// one item per cycle while not busy; each result passes through
// three multiply stages and an output register after the start transfer
// after reset and each node write (index 0 to 2) the six reciprocals are rebuilt,
// one quotient bit a cycle from the shared divider; busy stays high meanwhile
// results cannot be stalled
`default_nettype none
module newton_divided_difference_coefs_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    output logic o_busy,
    input  wire ndd_pkg::t_q i_stage_zero,
    input  wire ndd_pkg::t_q i_stage_one,
    input  wire ndd_pkg::t_q i_stage_two,
    input  wire ndd_pkg::t_q i_accepted_value,
    input  wire logic i_last_in,
    output logic o_strobe,
    output ndd_pkg::t_q o_coef_zero,
    output ndd_pkg::t_q o_coef_one,
    output ndd_pkg::t_q o_coef_two,
    output ndd_pkg::t_q o_coef_three,
    output logic o_last_out,
    output logic o_saturated,
    input  wire logic i_cfg_valid,
    output logic o_cfg_ready,
    input  wire logic [ndd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ndd_pkg::NODE_W-1:0] i_cfg_data
);
    ndd_pkg::t_q w_recip [ndd_pkg::NREC];
    logic w_clip;
    ndd_pkg::t_rec_status w_status;

    assign o_cfg_ready = 1'b1;
    assign o_busy = w_status.busy;

    ndd_recip u_recip (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_write(i_cfg_valid), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_recip(w_recip), .o_clip(w_clip), .o_status(w_status)
    );

    ndd_pipe u_pipe (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_start && w_status.done),
        .i_s0(i_stage_zero), .i_s1(i_stage_one), .i_s2(i_stage_two),
        .i_acc(i_accepted_value), .i_last(i_last_in),
        .i_recip(w_recip), .i_clip(w_clip),
        .o_valid(o_strobe), .o_c0(o_coef_zero), .o_c1(o_coef_one),
        .o_c2(o_coef_two), .o_c3(o_coef_three),
        .o_last(o_last_out), .o_sat(o_saturated)
    );
endmodule
`default_nettype wire
